// ===== design/fmt_pkg.sv =====
// shared types and constants for the fm timer and status block
`default_nettype none
package fmt_pkg;

  typedef enum logic [1:0] {
    CMD_ADDR = 2'd0,
    CMD_DATA = 2'd1,
    CMD_READ = 2'd2,
    CMD_TICK = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    FWD_NONE = 2'd0,
    FWD_ADDR = 2'd1,
    FWD_DATA = 2'd2
  } fwd_kind_t;

  localparam logic [7:0] ADDR_T1_RELOAD = 8'd2;
  localparam logic [7:0] ADDR_T2_RELOAD = 8'd3;
  localparam logic [7:0] ADDR_TCTRL     = 8'd4;

  localparam logic [7:0] FLAG_IRQ    = 8'h80;
  localparam logic [7:0] FLAG_T1     = 8'h40;
  localparam logic [7:0] FLAG_T2     = 8'h20;
  localparam logic [7:0] FLAG_TMASK  = 8'h60;
  localparam logic [7:0] FLAG_OTHERS = 8'h7f;

  localparam logic [8:0] RELOAD_BASE = 9'd256;

  typedef struct packed {
    logic [7:0] status_out;
    logic       irq;
    fwd_kind_t  forward_kind;
    logic [7:0] forward_value;
  } result_t;

endpackage
`default_nettype wire

// ===== design/fmt_core.sv =====
// timer, status and register state with the per-transaction update logic
`default_nettype none
module fmt_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           accept,
  input  wire fmt_pkg::cmd_t  command,
  input  wire logic [7:0]     data,
  output fmt_pkg::result_t    res
);
  import fmt_pkg::*;

  logic [7:0]  sel_addr_r, sel_addr_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [7:0]  ctrl_r, ctrl_nxt;
  logic [8:0]  t1_reload_r, t1_reload_nxt;
  logic [8:0]  t2_reload_r, t2_reload_nxt;
  logic [10:0] t1_count_r, t1_count_nxt;
  logic [12:0] t2_count_r, t2_count_nxt;
  logic        t1_run_r, t1_run_nxt;
  logic        t2_run_r, t2_run_nxt;
  logic [8:0]  new_reload;

  assign new_reload = RELOAD_BASE - {1'b0, data};

  always_comb begin
    sel_addr_nxt  = sel_addr_r;
    flags_nxt     = flags_r;
    ctrl_nxt      = ctrl_r;
    t1_reload_nxt = t1_reload_r;
    t2_reload_nxt = t2_reload_r;
    t1_count_nxt  = t1_count_r;
    t2_count_nxt  = t2_count_r;
    t1_run_nxt    = t1_run_r;
    t2_run_nxt    = t2_run_r;
    res.status_out    = 8'd0;
    res.forward_kind  = FWD_NONE;
    res.forward_value = 8'd0;
    case (command)
      CMD_ADDR: begin
        sel_addr_nxt = data;
        if (!(data inside {[ADDR_T1_RELOAD:ADDR_TCTRL]})) begin
          res.forward_kind  = FWD_ADDR;
          res.forward_value = data;
        end
      end
      CMD_DATA: begin
        if (sel_addr_r == ADDR_T1_RELOAD) begin
          t1_reload_nxt = new_reload;
        end else if (sel_addr_r == ADDR_T2_RELOAD) begin
          t2_reload_nxt = new_reload;
        end else if (sel_addr_r == ADDR_TCTRL) begin
          if (data[7]) begin
            flags_nxt = 8'd0;
          end else begin
            ctrl_nxt = data;
            if (data[0]) begin
              if (!t1_run_r) begin
                t1_count_nxt = {t1_reload_r, 2'b00};
                t1_run_nxt   = 1'b1;
              end
            end else begin
              t1_run_nxt = 1'b0;
            end
            if (data[1]) begin
              if (!t2_run_r) begin
                t2_count_nxt = {t2_reload_r, 4'b0000};
                t2_run_nxt   = 1'b1;
              end
            end else begin
              t2_run_nxt = 1'b0;
            end
            flags_nxt = flags_r & ~(data & FLAG_TMASK);
            if ((flags_nxt & FLAG_OTHERS) == 8'd0) begin
              flags_nxt = flags_nxt & FLAG_OTHERS;
            end
          end
        end else begin
          res.forward_kind  = FWD_DATA;
          res.forward_value = data;
        end
      end
      CMD_READ: begin
        res.status_out = flags_r & ~(ctrl_r & FLAG_TMASK);
      end
      CMD_TICK: begin
        if (t1_run_r) begin
          if (t1_count_r <= 11'd1) begin
            if ((ctrl_r & FLAG_T1) == 8'd0) begin
              flags_nxt = flags_nxt | FLAG_IRQ | FLAG_T1;
            end
            t1_count_nxt = {t1_reload_r, 2'b00};
          end else begin
            t1_count_nxt = t1_count_r - 11'd1;
          end
        end
        if (t2_run_r) begin
          if (t2_count_r <= 13'd1) begin
            if ((ctrl_r & FLAG_T2) == 8'd0) begin
              flags_nxt = flags_nxt | FLAG_IRQ | FLAG_T2;
            end
            t2_count_nxt = {t2_reload_r, 4'b0000};
          end else begin
            t2_count_nxt = t2_count_r - 13'd1;
          end
        end
      end
      default: begin
        sel_addr_nxt = sel_addr_r;
      end
    endcase
    res.irq = flags_nxt[7];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_addr_r  <= 8'd0;
      flags_r     <= 8'd0;
      ctrl_r      <= 8'd0;
      t1_reload_r <= RELOAD_BASE;
      t2_reload_r <= RELOAD_BASE;
      t1_count_r  <= 11'd0;
      t2_count_r  <= 13'd0;
      t1_run_r    <= 1'b0;
      t2_run_r    <= 1'b0;
    end else if (accept) begin
      sel_addr_r  <= sel_addr_nxt;
      flags_r     <= flags_nxt;
      ctrl_r      <= ctrl_nxt;
      t1_reload_r <= t1_reload_nxt;
      t2_reload_r <= t2_reload_nxt;
      t1_count_r  <= t1_count_nxt;
      t2_count_r  <= t2_count_nxt;
      t1_run_r    <= t1_run_nxt;
      t2_run_r    <= t2_run_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/fm_chip_timer_status_block_top.sv =====
// top level of the fm timer and status block with the result register
`default_nettype none
// Takes one transaction per clock: address write, data write, status read or
// one timer-base tick. Each accepted transaction updates the timer and status
// registers in the same cycle and yields exactly one result, held in a single
// output register and shown on the following cycle. While that register is
// full and stalled, in_stall is raised; otherwise a new transaction enters
// every cycle, so sustained throughput is one transaction per clock.
module fm_chip_timer_status_block_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_command,
  input  wire logic [7:0] in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_status_out,
  output logic            out_irq,
  output logic [1:0]      out_forward_kind,
  output logic [7:0]      out_forward_value
);
  import fmt_pkg::*;

  logic    out_valid_r, out_valid_nxt;
  result_t result_r;
  result_t core_res;
  logic    in_accept;

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  fmt_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .command (cmd_t'(in_command)),
    .data    (in_data),
    .res     (core_res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      result_r <= core_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status_out    = result_r.status_out;
  assign out_irq           = result_r.irq;
  assign out_forward_kind  = result_r.forward_kind;
  assign out_forward_value = result_r.forward_value;

endmodule
`default_nettype wire

// ===== design/fmt_chk.sv =====
// port-level checks for the fm timer and status block and their bind
`default_nettype none
module fmt_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [1:0] in_command,
  input wire logic [7:0] in_data,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_status_out,
  input wire logic       out_irq,
  input wire logic [1:0] out_forward_kind,
  input wire logic [7:0] out_forward_value
);
  import fmt_pkg::*;

  // no result is pending right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  // an accepted transaction appears as a result on the next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted transaction produced no result");

  // forwarding and status reads never share one transaction
  a_fwd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_forward_kind != FWD_NONE |-> out_status_out == 8'd0)
    else $error("forward and status in one result");

  // nothing forwarded means a zero byte and no unused kind
  a_fwd_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_forward_kind != FWD_NONE || out_forward_value == 8'd0)
                  && out_forward_kind != 2'd3)
    else $error("bad forward field");

endmodule

bind fm_chip_timer_status_block_top fmt_chk u_fmt_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_command        (in_command),
  .in_data           (in_data),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status_out    (out_status_out),
  .out_irq           (out_irq),
  .out_forward_kind  (out_forward_kind),
  .out_forward_value (out_forward_value)
);
`default_nettype wire
